[design/dap_pkg.sv]
package dap_pkg;

  // Address store size in bytes
  localparam int ADDR_BYTES = 64;
  localparam int LEN_W      = $clog2(ADDR_BYTES + 1);
  localparam int OUT_LEN_W  = 7;

  // Character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_CHAR  = 3'd1;
  localparam logic [2:0] ST_BAD_DOT   = 3'd2;
  localparam logic [2:0] ST_BAD_COLON = 3'd3;
  localparam logic [2:0] ST_NO_DOT    = 3'd4;
  localparam logic [2:0] ST_ODD_HEX   = 3'd5;
  localparam logic [2:0] ST_SHORT     = 3'd6;
  localparam logic [2:0] ST_OVERFLOW  = 3'd7;

  // Result kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic                  hex_mode;
    logic [1:0]            chars_seen;
    logic [1:0]            dot_count;
    logic                  colon_seen;
    logic [1:0]            cur_seg;
    logic                  nib_pend;
    logic [3:0]            high_nib;
    logic [3:0][LEN_W-1:0] seg_len;
    logic [LEN_W-1:0]      total;
    logic                  trail_sp;
    logic [2:0]            first_err;
  } parse_state_t;

  typedef struct packed {
    logic                      kind;
    logic                      last;
    logic [7:0]                data_byte;
    logic [1:0]                seg;
    logic [2:0]                status;
    logic                      has_parent;
    logic [3:0][OUT_LEN_W-1:0] seg_len;
  } result_t;

endpackage

[design/dap_step.sv]
module dap_step import dap_pkg::*; (
  input  parse_state_t st,
  input  logic [7:0]   char_code,
  input  logic         eos,
  output parse_state_t st_next,
  output logic         byte_v,
  output result_t      byte_res,
  output logic         stat_v,
  output result_t      stat_res
);

  parse_state_t s;
  logic         blank;
  logic         first;
  logic         is_hex;
  logic [3:0]   nib;
  logic         text_ok;
  logic         want_put;
  logic [7:0]   put_val;
  logic [2:0]   st_code;

  always_comb begin
    blank   = (char_code == CH_SPACE) || (char_code inside {[CH_TAB:CH_CR]});
    is_hex  = char_code inside {[CH_0:CH_9], [CH_LA:CH_LF], [CH_UA:CH_UF]};
    nib     = (char_code inside {[CH_0:CH_9]}) ? char_code[3:0] : 4'(char_code[3:0] + 4'd9);
    text_ok = (char_code > CH_SPACE) && (char_code <= CH_TILDE) &&
              (char_code != CH_COLON) && (char_code != CH_SLASH) &&
              (char_code != CH_DOT) && (char_code != CH_DOLLAR);

    s        = st;
    first    = 1'b0;
    want_put = 1'b0;
    put_val  = char_code;
    byte_v   = 1'b0;
    byte_res = '0;
    byte_res.kind = KIND_BYTE;

    if (blank) begin
      s.trail_sp = 1'b1;
    end else begin
      first = (st.chars_seen == 2'd0) && !st.trail_sp;
      if (st.trail_sp) begin
        // whitespace was not trailing after all
        if (s.first_err == ST_OK) s.first_err = ST_BAD_CHAR;
        s.trail_sp   = 1'b0;
        s.chars_seen = 2'd2;
      end else if (st.chars_seen < 2'd2) begin
        s.chars_seen = 2'(st.chars_seen + 2'd1);
      end

      if (first && char_code == CH_DOLLAR) begin
        s.hex_mode = 1'b1;
      end else if (char_code == CH_DOT) begin
        if (s.dot_count > 2'd1 || (s.dot_count == 2'd1 && !s.colon_seen)) begin
          if (s.first_err == ST_OK) s.first_err = ST_BAD_DOT;
        end else begin
          if (s.nib_pend && s.first_err == ST_OK) s.first_err = ST_ODD_HEX;
          s.dot_count = 2'(s.dot_count + 2'd1);
          s.cur_seg   = 2'(s.cur_seg + 2'd1);
        end
      end else if (char_code == CH_COLON) begin
        if (s.colon_seen || s.dot_count == 2'd0) begin
          if (s.first_err == ST_OK) s.first_err = ST_BAD_COLON;
        end else begin
          if (s.nib_pend && s.first_err == ST_OK) s.first_err = ST_ODD_HEX;
          s.colon_seen = 1'b1;
          s.cur_seg    = 2'(s.cur_seg + 2'd1);
        end
      end else if (s.hex_mode) begin
        if (!is_hex) begin
          if (s.first_err == ST_OK) s.first_err = ST_BAD_CHAR;
        end else if (!s.nib_pend) begin
          s.high_nib = nib;
          s.nib_pend = 1'b1;
        end else begin
          s.nib_pend = 1'b0;
          want_put   = 1'b1;
          put_val    = {s.high_nib, nib};
        end
      end else if (text_ok) begin
        want_put = 1'b1;
      end else begin
        if (s.first_err == ST_OK) s.first_err = ST_BAD_CHAR;
      end
    end

    // byte emit, gated by a kept error and the store size
    if (want_put && s.first_err == ST_OK) begin
      if (s.total >= LEN_W'(ADDR_BYTES)) begin
        s.first_err = ST_OVERFLOW;
      end else begin
        byte_v             = 1'b1;
        byte_res.data_byte = put_val;
        byte_res.seg       = s.cur_seg;
        s.seg_len[s.cur_seg] = LEN_W'(s.seg_len[s.cur_seg] + 1'b1);
        s.total            = LEN_W'(s.total + 1'b1);
      end
    end

    if (s.chars_seen < 2'd2) begin
      st_code = ST_SHORT;
    end else if (s.first_err != ST_OK) begin
      st_code = s.first_err;
    end else if (s.dot_count == 2'd0 || (s.colon_seen && s.dot_count < 2'd2)) begin
      st_code = ST_NO_DOT;
    end else if (s.nib_pend) begin
      st_code = ST_ODD_HEX;
    end else begin
      st_code = ST_OK;
    end

    stat_v              = eos;
    stat_res            = '0;
    stat_res.kind       = KIND_STATUS;
    stat_res.last       = 1'b1;
    stat_res.status     = st_code;
    stat_res.has_parent = s.colon_seen;
    for (int i = 0; i < 4; i++) begin
      stat_res.seg_len[i] = OUT_LEN_W'(s.seg_len[i]);
    end

    st_next = eos ? parse_state_t'('0) : s;
  end

endmodule

[design/dotted_address_text_parser.sv]
// Dotted address text parser.
// Input stream (s_*): one character per item, s_tdata = char_code,
// s_tlast = end_of_string on the final character of a string.
// Output stream (m_*): converted address bytes (m_tuser = 0) followed, for
// the last character, by one status record (m_tuser = 1, m_tlast = 1)
// carrying the status code, parent flag and four segment lengths.
// Each accepted character is parsed in the cycle it is accepted; its zero,
// one or two results land in a four-entry output queue and are offered
// from the next cycle if the queue was empty.
// Throughput: one character per cycle while the queue has room for two
// results; s_tready is low when more than two results are queued. A stalled
// receiver fills the queue and then holds off the input, nothing is lost.
// Parser state returns to its reset values after every end-of-string item.
// Reset (rst, synchronous) clears the parser state and empties the queue.
module dotted_address_text_parser import dap_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // end_of_string
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] data_byte, [9:8] segment_ordinal, [12:10] status_code,
  // [13] has_parent, [20:14] seg0_len, [27:21] seg1_len,
  // [34:28] seg2_len, [41:35] seg3_len, [47:42] zero
  output logic [47:0] m_tdata,
  output logic        m_tuser,   // result_kind
  output logic        m_tlast    // last_of_run
);

  parse_state_t st;
  parse_state_t st_next;
  logic         byte_v;
  logic         stat_v;
  result_t      byte_res;
  result_t      stat_res;

  dap_step u_step (
    .st        (st),
    .char_code (s_tdata),
    .eos       (s_tlast),
    .st_next   (st_next),
    .byte_v    (byte_v),
    .byte_res  (byte_res),
    .stat_v    (stat_v),
    .stat_res  (stat_res)
  );

  // Output queue
  result_t    q [4];
  logic [1:0] head;
  logic [1:0] wptr;
  logic [2:0] count;
  logic [2:0] count_next;
  logic       acc;
  logic       pop;
  logic [1:0] npush;
  result_t    push0;
  result_t    push1;
  result_t    hd;

  assign acc      = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;
  assign s_tready = (count <= 3'd2);
  assign m_tvalid = (count != 3'd0);

  always_comb begin
    npush = acc ? (2'(byte_v) + 2'(stat_v)) : 2'd0;
    push0 = byte_v ? byte_res : stat_res;
    push1 = stat_res;
    count_next = 3'(count + 3'(npush) - 3'(pop));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= '0;
      head  <= '0;
      wptr  <= '0;
      count <= '0;
    end else begin
      if (acc) st <= st_next;
      if (pop) head <= 2'(head + 2'd1);
      wptr  <= 2'(wptr + npush);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (npush != 2'd0) q[wptr] <= push0;
    if (npush == 2'd2) q[2'(wptr + 2'd1)] <= push1;
  end

  assign hd      = q[head];
  assign m_tuser = hd.kind;
  assign m_tlast = hd.last;
  assign m_tdata = {6'd0, hd.seg_len[3], hd.seg_len[2], hd.seg_len[1], hd.seg_len[0],
                    hd.has_parent, hd.status, hd.seg, hd.data_byte};

endmodule
